// File: rtl/gbi_pkg.sv
`default_nettype none

package gbi_pkg;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 6;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [8:0]  RST_GRID_SIZE = 9'd256;
    localparam logic [31:0] RST_SPACING   = 32'h0001_0000;

    // quotient bits per divider pass
    localparam logic [CNT_W-1:0] DIV_INDEX_STEPS  = 6'd32;
    localparam logic [CNT_W-1:0] DIV_WEIGHT_STEPS = 6'd17;

    typedef struct packed {
        logic             start;
        logic [31:0]      rem_init;
        logic [31:0]      dvd_init;
        logic [31:0]      divisor;
        logic [CNT_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/gbi_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The partial remainder is
// preloaded (must be below the divisor) and dividend bits enter MSB first.
module gbi_divider
    import gbi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire div_ctl_t  ctl,
    output div_stat_t      stat,
    output logic [31:0]    quotient,
    output logic [31:0]    remainder
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      dvd_reg;
    logic [31:0]      dv_reg;
    logic [31:0]      q_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        fits;
    logic [31:0] rem_next;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[31]};
        diff     = shifted - {1'b0, dv_reg};
        fits     = (shifted >= {1'b0, dv_reg});
        rem_next = fits ? diff[31:0] : shifted[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= ctl.rem_init;
            dvd_reg <= ctl.dvd_init;
            dv_reg  <= ctl.divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            q_reg   <= {q_reg[30:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: rtl/gbi_grid_mem.sv
`default_nettype none

module gbi_grid_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [31:0]       wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [31:0]            rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/grid_bilinear_interpolator.sv
`default_nettype none

// Bilinear interpolator over a stored grid of signed Q16.16 samples. A load
// (opcode 0) writes one sample. A query (opcode 1) uses one shared radix-2
// divider (one quotient bit per cycle): two 32-bit index divisions, then on
// the interior path two 17-bit weight divisions and four corner passes of
// read, two multiplies and accumulate on one shared multiplier; the border
// path reads one clamped sample instead.
// in_ready is high only between queries; a finished result waits in the
// output register while loads keep flowing. The sample store is not cleared
// at reset: read only cells that were loaded.
module grid_bilinear_interpolator
    import gbi_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 opcode,
    input  wire logic [7:0]           load_col,
    input  wire logic [7:0]           load_row,
    input  wire logic signed [31:0]   sample_value,
    input  wire logic signed [31:0]   query_x,
    input  wire logic signed [31:0]   query_y,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        result_value,
    output logic                      clamped
);

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int NX_W   = $clog2(MAX_COLS + 1);
    localparam int NY_W   = $clog2(MAX_ROWS + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DIVX   = 12'b0000_0000_0010,
        S_DIVY   = 12'b0000_0000_0100,
        S_DECIDE = 12'b0000_0000_1000,
        S_WX     = 12'b0000_0001_0000,
        S_WY     = 12'b0000_0010_0000,
        S_CRD    = 12'b0000_0100_0000,
        S_CM1    = 12'b0000_1000_0000,
        S_CM2    = 12'b0001_0000_0000,
        S_CACC   = 12'b0010_0000_0000,
        S_BRD    = 12'b0100_0000_0000,
        S_FIN    = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]  grid_cols_reg;
    logic [8:0]  grid_rows_reg;
    logic [31:0] cell_width_reg;
    logic [31:0] cell_height_reg;

    logic              x_neg_reg, y_neg_reg;
    logic [31:0]       y_abs_reg;
    logic [31:0]       qx_reg, qy_reg, remx_reg, remy_reg;
    logic [16:0]       wx_reg, wy_reg;
    logic [COL_W-1:0]  ci_reg;
    logic [ROW_W-1:0]  cj_reg;
    logic [1:0]        k_reg;
    logic              flag_reg;
    logic signed [51:0] prod_reg;
    logic signed [37:0] acc_reg;

    logic              out_valid_reg;
    logic signed [31:0] result_value_reg;
    logic              clamped_reg;

    div_ctl_t    div_ctl;
    div_stat_t   div_st;
    logic [31:0] div_q, div_rem;

    logic        accept;
    logic        slot_free;
    logic [31:0] dx_eff, dy_eff;
    logic [31:0] x_abs, y_abs;
    logic [NX_W-1:0] nx_eff;
    logic [NY_W-1:0] ny_eff;
    logic        neg_i, neg_j, border;
    logic [COL_W-1:0] ci_clamp;
    logic [ROW_W-1:0] cj_clamp;
    logic [32:0] num_x, num_y;

    logic signed [17:0] wx_s, wy_s, ux_s, uy_s, wa_s, wb_s;
    logic signed [19:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [51:0] mul_p;
    logic signed [35:0] term;
    logic signed [37:0] acc_sum;
    logic signed [31:0] acc_sat;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]       mem_rdata;
    logic [COL_W-1:0]  rd_col;
    logic [ROW_W-1:0]  rd_row;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg   <= RST_GRID_SIZE;
            grid_rows_reg   <= RST_GRID_SIZE;
            cell_width_reg  <= RST_SPACING;
            cell_height_reg <= RST_SPACING;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_COLS:   grid_cols_reg   <= cfg_data[8:0];
                CFG_GRID_ROWS:   grid_rows_reg   <= cfg_data[8:0];
                CFG_CELL_WIDTH:  cell_width_reg  <= cfg_data;
                CFG_CELL_HEIGHT: cell_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        dx_eff = (cell_width_reg == 32'd0) ? 32'd1 : cell_width_reg;
        dy_eff = (cell_height_reg == 32'd0) ? 32'd1 : cell_height_reg;
        x_abs  = query_x[31] ? (~query_x + 32'd1) : query_x;
        y_abs  = query_y[31] ? (~query_y + 32'd1) : query_y;

        if (grid_cols_reg == 9'd0)
            nx_eff = NX_W'(1);
        else if (32'(grid_cols_reg) > 32'(MAX_COLS))
            nx_eff = NX_W'(MAX_COLS);
        else
            nx_eff = NX_W'(grid_cols_reg);

        if (grid_rows_reg == 9'd0)
            ny_eff = NY_W'(1);
        else if (32'(grid_rows_reg) > 32'(MAX_ROWS))
            ny_eff = NY_W'(MAX_ROWS);
        else
            ny_eff = NY_W'(grid_rows_reg);

        // a negative position that truncates to index 0 is still interior
        neg_i  = x_neg_reg && (qx_reg != 32'd0);
        neg_j  = y_neg_reg && (qy_reg != 32'd0);
        border = neg_i || neg_j
              || (qx_reg >= 32'(nx_eff) - 32'd1)
              || (qy_reg >= 32'(ny_eff) - 32'd1);

        if (neg_i)
            ci_clamp = '0;
        else if (qx_reg >= 32'(nx_eff))
            ci_clamp = COL_W'(32'(nx_eff) - 32'd1);
        else
            ci_clamp = qx_reg[COL_W-1:0];

        if (neg_j)
            cj_clamp = '0;
        else if (qy_reg >= 32'(ny_eff))
            cj_clamp = ROW_W'(32'(ny_eff) - 32'd1);
        else
            cj_clamp = qy_reg[ROW_W-1:0];

        // d - r, where r carries the sign of the position
        num_x = x_neg_reg ? ({1'b0, dx_eff} + {1'b0, remx_reg})
                          : ({1'b0, dx_eff} - {1'b0, remx_reg});
        num_y = y_neg_reg ? ({1'b0, dy_eff} + {1'b0, remy_reg})
                          : ({1'b0, dy_eff} - {1'b0, remy_reg});
    end

    // divider requests
    always_comb
    begin
        div_ctl.start    = 1'b0;
        div_ctl.rem_init = '0;
        div_ctl.dvd_init = x_abs;
        div_ctl.divisor  = dx_eff;
        div_ctl.steps    = DIV_INDEX_STEPS;
        case (state_reg)
            S_IDLE:
            begin
                div_ctl.start = accept && (opcode == OP_QUERY);
            end
            S_DIVX:
            begin
                div_ctl.start    = div_st.done;
                div_ctl.dvd_init = y_abs_reg;
                div_ctl.divisor  = dy_eff;
            end
            S_DECIDE:
            begin
                div_ctl.start    = !border;
                div_ctl.rem_init = num_x[32:1];
                div_ctl.dvd_init = {num_x[0], 31'd0};
                div_ctl.steps    = DIV_WEIGHT_STEPS;
            end
            S_WX:
            begin
                div_ctl.start    = div_st.done;
                div_ctl.rem_init = num_y[32:1];
                div_ctl.dvd_init = {num_y[0], 31'd0};
                div_ctl.divisor  = dy_eff;
                div_ctl.steps    = DIV_WEIGHT_STEPS;
            end
            default: ;
        endcase
    end

    gbi_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (div_ctl),
        .stat      (div_st),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    // shared multiplier
    always_comb
    begin
        wx_s = $signed({1'b0, wx_reg});
        wy_s = $signed({1'b0, wy_reg});
        ux_s = 18'sd65536 - wx_s;
        uy_s = 18'sd65536 - wy_s;
        wa_s = k_reg[0] ? ux_s : wx_s;
        wb_s = k_reg[1] ? uy_s : wy_s;
        if (state_reg == S_CM2)
        begin
            mul_a = prod_reg[35:16];
            mul_b = $signed(mem_rdata);
        end
        else
        begin
            mul_a = 20'(wa_s);
            mul_b = 32'(wb_s);
        end
        mul_p   = mul_a * mul_b;
        term    = prod_reg[51:16];
        acc_sum = acc_reg + 38'(term);
        if (acc_reg > 38'sd2147483647)
            acc_sat = 32'sh7fff_ffff;
        else if (acc_reg < -38'sd2147483648)
            acc_sat = 32'sh8000_0000;
        else
            acc_sat = acc_reg[31:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept && (opcode == OP_QUERY)) state_next = S_DIVX;
            S_DIVX:   if (div_st.done) state_next = S_DIVY;
            S_DIVY:   if (div_st.done) state_next = S_DECIDE;
            S_DECIDE: state_next = border ? S_BRD : S_WX;
            S_WX:     if (div_st.done) state_next = S_WY;
            S_WY:     if (div_st.done) state_next = S_CRD;
            S_CRD:    state_next = S_CM1;
            S_CM1:    state_next = S_CM2;
            S_CM2:    state_next = S_CACC;
            S_CACC:   state_next = (k_reg == 2'd3) ? S_FIN : S_CRD;
            S_BRD:    state_next = S_FIN;
            S_FIN:    if (slot_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_FIN) && slot_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                x_neg_reg <= query_x[31];
                y_neg_reg <= query_y[31];
                y_abs_reg <= y_abs;
            end
            S_DIVX:
            begin
                qx_reg   <= div_q;
                remx_reg <= div_rem;
            end
            S_DIVY:
            begin
                qy_reg   <= div_q;
                remy_reg <= div_rem;
            end
            S_DECIDE:
            begin
                flag_reg <= border;
                ci_reg   <= border ? ci_clamp : qx_reg[COL_W-1:0];
                cj_reg   <= border ? cj_clamp : qy_reg[ROW_W-1:0];
                k_reg    <= 2'd0;
            end
            S_WX:
            begin
                wx_reg <= div_q[16:0];
            end
            S_WY:
            begin
                wy_reg  <= div_q[16:0];
                acc_reg <= '0;
            end
            S_CM1, S_CM2:
            begin
                prod_reg <= mul_p;
            end
            S_CACC:
            begin
                acc_reg <= acc_sum;
                k_reg   <= k_reg + 2'd1;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    result_value_reg <= flag_reg ? $signed(mem_rdata) : acc_sat;
                    clamped_reg      <= flag_reg;
                end
            end
            default: ;
        endcase
    end

    // sample store
    assign rd_col    = ci_reg + COL_W'(k_reg[0]);
    assign rd_row    = cj_reg + ROW_W'(k_reg[1]);
    assign mem_raddr = ADDR_W'(rd_row) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col);
    assign mem_re    = (state_reg == S_CRD) || (state_reg == S_BRD);
    assign mem_we    = accept && (opcode == OP_LOAD)
                    && (32'(load_col) < 32'(MAX_COLS))
                    && (32'(load_row) < 32'(MAX_ROWS));
    assign mem_waddr = ADDR_W'(load_row) * ADDR_W'(MAX_COLS) + ADDR_W'(load_col);

    gbi_grid_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (sample_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign clamped      = clamped_reg;

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |-> !div_st.busy)
        else $error("divider restarted while busy");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.done |-> (state_reg == S_DIVX || state_reg == S_DIVY
                         || state_reg == S_WX || state_reg == S_WY))
        else $error("divider finished outside a divide state");

    a_corner_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CRD) |-> !flag_reg)
        else $error("corner read on a border query");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !mem_re)
        else $error("sample store written and read in one cycle");

endmodule

`default_nettype wire

// File: tb/grid_bilinear_interpolator_tb.sv
`default_nettype none

module grid_bilinear_interpolator_tb;
    import gbi_pkg::*;

    localparam int NCOLS = 256;
    localparam int NROWS = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [31:0] value;
        logic               clamped;
    } interp_result_t;

    class interp_scoreboard;
        logic signed [31:0] samples [int];
        logic [8:0]         cols_reg;
        logic [8:0]         rows_reg;
        logic [31:0]        width_reg;
        logic [31:0]        height_reg;
        interp_result_t     pending[$];
        int                 errors;
        int                 checked;
        int                 clamp_seen;

        function new();
            cols_reg   = 9'd256;
            rows_reg   = 9'd256;
            width_reg  = 32'h0001_0000;
            height_reg = 32'h0001_0000;
            errors     = 0;
            checked    = 0;
            clamp_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_GRID_COLS:   cols_reg   = data[8:0];
                CFG_GRID_ROWS:   rows_reg   = data[8:0];
                CFG_CELL_WIDTH:  width_reg  = data;
                CFG_CELL_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function longint floor16(longint v);
            return v >>> 16;
        endfunction

        function longint trunc_q(longint p, longint d);
            return (p < 0) ? -((-p) / d) : p / d;
        endfunction

        function longint sample(longint c, longint r);
            return longint'(samples[int'(r * NCOLS + c)]);
        endfunction

        function longint eff(logic [8:0] v, longint mx);
            if (v == 0) return 1;
            if (longint'(v) > mx) return mx;
            return longint'(v);
        endfunction

        // notes an accepted input transaction and, for a query, queues its expected result
        function void note_input(logic op, logic [7:0] col, logic [7:0] row,
                                 logic signed [31:0] sv, logic signed [31:0] qx,
                                 logic signed [31:0] qy);
            longint nx, ny, dx, dy, x, y, i, j, ci, cj, wx, wy, ux, uy, acc;
            interp_result_t res;
            if (op == OP_LOAD)
            begin
                samples[int'(row) * NCOLS + int'(col)] = sv;
                return;
            end
            nx = eff(cols_reg, NCOLS);
            ny = eff(rows_reg, NROWS);
            dx = (width_reg == 0) ? 1 : longint'(width_reg);
            dy = (height_reg == 0) ? 1 : longint'(height_reg);
            x = longint'(qx);
            y = longint'(qy);
            i = trunc_q(x, dx);
            j = trunc_q(y, dy);
            if (i < 0 || j < 0 || i >= nx - 1 || j >= ny - 1)
            begin
                ci = (i < 0) ? 0 : (i >= nx) ? nx - 1 : i;
                cj = (j < 0) ? 0 : (j >= ny) ? ny - 1 : j;
                res.value   = 32'(sample(ci, cj));
                res.clamped = 1'b1;
            end
            else
            begin
                wx = ((dx - (x - i * dx)) * 65536) / dx;
                wy = ((dy - (y - j * dy)) * 65536) / dy;
                ux = 65536 - wx;
                uy = 65536 - wy;
                acc = floor16(floor16(wx * wy) * sample(i, j))
                    + floor16(floor16(ux * wy) * sample(i + 1, j))
                    + floor16(floor16(wx * uy) * sample(i, j + 1))
                    + floor16(floor16(ux * uy) * sample(i + 1, j + 1));
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                res.value   = 32'(acc);
                res.clamped = 1'b0;
            end
            pending.push_back(res);
        endfunction

        function void check_result(logic signed [31:0] value, logic clamp);
            interp_result_t exp_res;
            if (pending.size() == 0)
            begin
                $error("unexpected result value=%0d clamped=%0b", value, clamp);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            checked++;
            if (clamp) clamp_seen++;
            if (value !== exp_res.value)
            begin
                $error("result_value: expected %0d actual %0d", exp_res.value, value);
                errors++;
            end
            if (clamp !== exp_res.clamped)
            begin
                $error("clamped: expected %0b actual %0b", exp_res.clamped, clamp);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_GRID_COLS;
    logic [31:0]          cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 opcode = OP_LOAD;
    logic [7:0]           load_col = '0;
    logic [7:0]           load_row = '0;
    logic signed [31:0]   sample_value = '0;
    logic signed [31:0]   query_x = '0;
    logic signed [31:0]   query_y = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [31:0]   result_value;
    logic                 clamped;

    interp_scoreboard sb = new();
    bit  sink_calm = 0;
    bit  src_calm = 0;
    bit  hold_sink = 0;
    int  idle_cycles = 0;
    int  queries_sent = 0;

    always #2 clk = ~clk;

    grid_bilinear_interpolator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
        .load_col(load_col), .load_row(load_row), .sample_value(sample_value),
        .query_x(query_x), .query_y(query_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_value(result_value), .clamped(clamped)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(opcode, load_col, load_row, sample_value, query_x, query_y);
            if (out_valid && out_ready)
                sb.check_result(result_value, clamped);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", sb.pending.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, long hold-off on request
    always @(negedge clk)
    begin
        if (hold_sink)
            out_ready <= 1'b0;
        else if (sink_calm)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 27);
    end

    // valid stays up after acceptance so transactions can go back to back;
    // an idle cycle or drain() drops it
    task automatic send(logic op, logic [7:0] col, logic [7:0] row,
                        logic [31:0] sv, logic [31:0] qx, logic [31:0] qy);
        while (!src_calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        load_col     <= col;
        load_row     <= row;
        sample_value <= sv;
        query_x      <= qx;
        query_y      <= qy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (op == OP_QUERY) queries_sent++;
    endtask

    task automatic load(int c, int r, logic [31:0] v);
        send(OP_LOAD, 8'(c), 8'(r), v, $urandom, $urandom);
    endtask

    task automatic query(logic [31:0] qx, logic [31:0] qy);
        send(OP_QUERY, 8'($urandom), 8'($urandom), $urandom, qx, qy);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_grid(int c, int r, logic [31:0] w, logic [31:0] h);
        drain();
        write_cfg(CFG_GRID_COLS, 32'(c));
        write_cfg(CFG_GRID_ROWS, 32'(r));
        write_cfg(CFG_CELL_WIDTH, w);
        write_cfg(CFG_CELL_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // position around the loaded area along one axis, spacing d, n cells
    function automatic logic [31:0] rand_pos(logic [31:0] d, int n);
        longint p;
        case ($urandom_range(9))
            0: return $urandom;
            1: p = -longint'($urandom_range(d > 1 ? 1 : 0) * (d - 1) / 2);
            2: p = longint'(n - 1) * d + $urandom_range(3);
            default: p = longint'($urandom_range(n > 1 ? n - 2 : 0)) * d
                         + longint'($urandom) % longint'(d);
        endcase
        if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
        return 32'(p);
    endfunction

    task automatic load_area(int c, int r);
        for (int rr = 0; rr < r; rr++)
            for (int cc = 0; cc < c; cc++)
                load(cc, rr, rand_sample());
    endtask

    task automatic random_phase(int n, int c, int r, logic [31:0] w, logic [31:0] h);
        logic [31:0] qx, qy;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(3) == 0)
            begin
                load($urandom_range(c - 1), $urandom_range(r - 1), rand_sample());
            end
            else
            begin
                qx = rand_pos(w, c);
                qy = rand_pos(h, r);
                // keep every read inside the loaded cells
                if ($signed(qx) > 0 && c < 256
                        && longint'($signed(qx)) / longint'(w) >= c)
                    qx = 32'(longint'(c - 1) * w);
                if ($signed(qy) > 0 && r < 256
                        && longint'($signed(qy)) / longint'(h) >= r)
                    qy = 32'(longint'(r - 1) * h);
                query(qx, qy);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // small grid, unit spacing: corner loads and directed queries
        set_grid(4, 4, 32'h0001_0000, 32'h0001_0000);
        load_area(4, 4);
        load(255, 255, 32'h8000_0000);
        load(255, 0, 32'h7FFF_FFFF);
        load(0, 255, 32'h0000_0001);
        query(32'h0000_8000, 32'h0000_8000);
        query(32'h0000_0000, 32'h0000_0000);
        query(32'hFFFF_8000, 32'h0000_4000);   // small negative: extrapolate
        query(32'h8000_0000, 32'h7FFF_FFFF);
        query(32'h7FFF_FFFF, 32'h8000_0000);
        query(32'h0003_0000, 32'h0001_0000);   // last column
        query(32'h0002_FFFF, 32'h0002_FFFF);
        query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query(32'hFFFE_0000, 32'h0001_0000);   // negative index

        // receiver holds off while sender keeps offering queries
        drain();
        hold_sink = 1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_sink = 0;
            end
            for (int k = 0; k < 8; k++)
                query(rand_pos(32'h0001_0000, 4), rand_pos(32'h0001_0000, 4));
        join

        // size 0 acts as 1, oversize acts as max; zero spacing
        set_grid(0, 511, 32'h0000_0000, 32'h0000_0000);
        query(32'h0000_0000, 32'h0000_0002);
        query(32'hFFFF_FFFF, 32'h0000_0001);
        // row index lands below zero or past the last row
        query($urandom, $urandom | 32'h0100_0000);

        set_grid(4, 4, 32'h0001_0000, 32'h0001_0000);
        random_phase(200, 4, 4, 32'h0001_0000, 32'h0001_0000);

        set_grid(2, 2, 32'h0000_0001, 32'hFFFF_FFFF);
        random_phase(100, 2, 2, 32'h0000_0001, 32'hFFFF_FFFF);

        set_grid(8, 6, 32'h0002_8000, 32'h0000_3000);
        load_area(8, 6);
        random_phase(200, 8, 6, 32'h0002_8000, 32'h0000_3000);

        // full grid size, big spacing so positions stay near origin
        src_calm = 1;
        sink_calm = 1;
        set_grid(256, 256, 32'h0100_0000, 32'h0100_0000);
        random_phase(60, 4, 4, 32'h0100_0000, 32'h0100_0000);
        src_calm = 0;
        sink_calm = 0;
        random_phase(200, 4, 4, 32'h0100_0000, 32'h0100_0000);

        drain();
        $display("sent %0d queries, checked %0d results (%0d clamped)",
                 queries_sent, sb.checked, sb.clamp_seen);
        $display("covered border, interior and extrapolation over several grid settings");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
